// ===== src/glpd_pkg.sv =====
package glpd_pkg;

    localparam int SAMPLE_BITS    = 32;
    localparam int MAX_ROW_LENGTH = 4096;
    localparam int MAX_ROWS       = 4096;
    localparam int COL_BITS       = $clog2(MAX_ROW_LENGTH);
    localparam int ROW_BITS       = $clog2(MAX_ROWS);

    localparam int THR_BITS       = 31;
    localparam int DIM_BITS       = 13;
    localparam int CFG_DATA_BITS  = 31;
    localparam int CFG_IDX_BITS   = 2;
    localparam int MIN_DIM        = 3;

    localparam int QUEUE_DEPTH    = 4;
    localparam int QPTR_BITS      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_THRESHOLD,
        CFG_ROW_LENGTH,
        CFG_ROW_COUNT,
        CFG_FIND_NEGATIVE
    } t_cfg_reg;

    typedef struct packed {
        logic [COL_BITS-1:0]           x;
        logic [ROW_BITS-1:0]           y;
        logic signed [SAMPLE_BITS-1:0] value;
        logic                          neg;
    } t_peak;

    typedef struct packed {
        logic                 not_empty;
        logic [QCNT_BITS-1:0] count;
    } t_q_status;

endpackage

// ===== src/glpd_front.sv =====
module glpd_front (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic signed [glpd_pkg::SAMPLE_BITS-1:0] i_sample,
    input  logic                                  i_cfg_we,
    input  logic [glpd_pkg::CFG_IDX_BITS-1:0]     i_cfg_index,
    input  logic [glpd_pkg::CFG_DATA_BITS-1:0]    i_cfg_data,
    input  glpd_pkg::t_q_status                   i_q_status,
    output logic                                  o_push,
    output glpd_pkg::t_peak                       o_peak
);

    localparam int SB = glpd_pkg::SAMPLE_BITS;
    localparam int CB = glpd_pkg::COL_BITS;
    localparam int RB = glpd_pkg::ROW_BITS;

    function automatic logic [glpd_pkg::DIM_BITS-2:0] last_index(
        input logic [glpd_pkg::DIM_BITS-1:0] d,
        input int                            max_dim
    );
        logic [glpd_pkg::DIM_BITS-1:0] lim;
        logic [glpd_pkg::DIM_BITS-1:0] res;
        lim = glpd_pkg::DIM_BITS'(max_dim);
        if (d < glpd_pkg::DIM_BITS'(glpd_pkg::MIN_DIM)) begin
            res = glpd_pkg::DIM_BITS'(glpd_pkg::MIN_DIM - 1);
        end else if (d > lim) begin
            res = lim - 1'b1;
        end else begin
            res = d - 1'b1;
        end
        return res[glpd_pkg::DIM_BITS-2:0];
    endfunction

    // configuration
    logic [glpd_pkg::THR_BITS-1:0] r_threshold;
    logic [CB-1:0]                 r_last_col;
    logic [RB-1:0]                 r_last_row;
    logic                          r_find_neg;

    // position of the next word
    logic [CB-1:0] r_col, n_col;
    logic [RB-1:0] r_row, n_row;

    // stage 1
    logic                 r_s1_valid;
    logic [CB-1:0]        r_s1_col;
    logic [RB-1:0]        r_s1_row;
    logic signed [SB-1:0] r_s1_sample;

    // line stores and their read registers
    logic signed [SB-1:0] r_mid_mem [glpd_pkg::MAX_ROW_LENGTH];
    logic signed [SB-1:0] r_old_mem [glpd_pkg::MAX_ROW_LENGTH];
    logic signed [SB-1:0] r_mid_rd;
    logic signed [SB-1:0] r_old_rd;

    // cross window
    logic signed [SB-1:0] r_win_left;
    logic signed [SB-1:0] r_win_center;
    logic signed [SB-1:0] r_win_down;
    logic signed [SB-1:0] r_win_up;

    logic [glpd_pkg::QCNT_BITS:0] w_used;
    logic                         w_acc;
    logic                         w_restart;
    logic signed [SB:0]           w_center_x;
    logic signed [SB:0]           w_thr_x;
    logic                         w_interior;
    logic                         w_pos;
    logic                         w_neg;

    assign w_used  = (glpd_pkg::QCNT_BITS+1)'(i_q_status.count)
                   + (glpd_pkg::QCNT_BITS+1)'(r_s1_valid);
    assign o_stall = w_used >= (glpd_pkg::QCNT_BITS+1)'(glpd_pkg::QUEUE_DEPTH);
    assign w_acc   = i_valid && !o_stall;

    assign w_restart = i_cfg_we
        && (glpd_pkg::t_cfg_reg'(i_cfg_index) == glpd_pkg::CFG_ROW_LENGTH
         || glpd_pkg::t_cfg_reg'(i_cfg_index) == glpd_pkg::CFG_ROW_COUNT);

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (w_restart) begin
            n_col = '0;
            n_row = '0;
        end else if (w_acc) begin
            if (r_col == r_last_col) begin
                n_col = '0;
                n_row = (r_row == r_last_row) ? '0 : r_row + 1'b1;
            end else begin
                n_col = r_col + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= '0;
            r_last_col  <= CB'(glpd_pkg::MAX_ROW_LENGTH - 1);
            r_last_row  <= RB'(glpd_pkg::MAX_ROWS - 1);
            r_find_neg  <= 1'b0;
            r_col       <= '0;
            r_row       <= '0;
            r_s1_valid  <= 1'b0;
        end else begin
            r_col      <= n_col;
            r_row      <= n_row;
            r_s1_valid <= w_acc;
            if (i_cfg_we) begin
                unique case (glpd_pkg::t_cfg_reg'(i_cfg_index))
                    glpd_pkg::CFG_THRESHOLD: begin
                        r_threshold <= i_cfg_data[glpd_pkg::THR_BITS-1:0];
                    end
                    glpd_pkg::CFG_ROW_LENGTH: begin
                        r_last_col <= CB'(last_index(i_cfg_data[glpd_pkg::DIM_BITS-1:0],
                                                     glpd_pkg::MAX_ROW_LENGTH));
                    end
                    glpd_pkg::CFG_ROW_COUNT: begin
                        r_last_row <= RB'(last_index(i_cfg_data[glpd_pkg::DIM_BITS-1:0],
                                                     glpd_pkg::MAX_ROWS));
                    end
                    glpd_pkg::CFG_FIND_NEGATIVE: begin
                        r_find_neg <= i_cfg_data[0];
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_s1_col    <= r_col;
            r_s1_row    <= r_row;
            r_s1_sample <= i_sample;
        end
    end

    // centre row store: written in the cycle after its read, at the same column
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_mid_rd <= r_mid_mem[r_col];
        end
        if (r_s1_valid) begin
            r_mid_mem[r_s1_col] <= r_s1_sample;
        end
    end

    // upper row store takes over what the centre row store held
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_old_rd <= r_old_mem[r_col];
        end
        if (r_s1_valid) begin
            r_old_mem[r_s1_col] <= r_mid_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_left   <= '0;
            r_win_center <= '0;
            r_win_down   <= '0;
            r_win_up     <= '0;
        end else if (r_s1_valid) begin
            r_win_left   <= r_win_center;
            r_win_center <= r_mid_rd;
            r_win_down   <= r_s1_sample;
            r_win_up     <= r_old_rd;
        end
    end

    assign w_center_x = {r_win_center[SB-1], r_win_center};
    assign w_thr_x    = signed'((SB+1)'(r_threshold));
    assign w_interior = (r_s1_col >= CB'(2)) && (r_s1_row >= RB'(2));

    assign w_pos = (w_center_x > w_thr_x)
                && (r_win_center > r_win_left) && (r_win_center > r_mid_rd)
                && (r_win_center > r_win_up)   && (r_win_center > r_win_down);
    assign w_neg = r_find_neg && (w_center_x < -w_thr_x)
                && (r_win_center < r_win_left) && (r_win_center < r_mid_rd)
                && (r_win_center < r_win_up)   && (r_win_center < r_win_down);

    assign o_push       = r_s1_valid && w_interior && (w_pos || w_neg);
    assign o_peak.x     = r_s1_col - 1'b1;
    assign o_peak.y     = r_s1_row - 1'b1;
    assign o_peak.value = r_win_center;
    assign o_peak.neg   = w_neg;

    a_col_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= r_last_col)
        else $error("column counter past end of row");

    a_row_in_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row <= r_last_row)
        else $error("row counter past end of grid");

    a_pos_neg_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && w_interior) |-> !(w_pos && w_neg))
        else $error("positive and negative peak at once");

endmodule

// ===== src/glpd_queue.sv =====
module glpd_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  glpd_pkg::t_peak      i_peak,
    input  logic                 i_pop,
    output glpd_pkg::t_peak      o_head,
    output glpd_pkg::t_q_status  o_status
);

    localparam int PB = glpd_pkg::QPTR_BITS;
    localparam int NB = glpd_pkg::QCNT_BITS;

    glpd_pkg::t_peak r_mem [glpd_pkg::QUEUE_DEPTH];
    logic [PB-1:0]   r_wr_ptr;
    logic [PB-1:0]   r_rd_ptr;
    logic [NB-1:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_peak;
        end
    end

    assign o_head             = r_mem[r_rd_ptr];
    assign o_status.count     = r_count;
    assign o_status.not_empty = r_count != '0;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && !i_pop && r_count == NB'(glpd_pkg::QUEUE_DEPTH)))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && r_count == '0))
        else $error("pop from empty queue");

endmodule

// ===== src/glpd_back.sv =====
module glpd_back (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  glpd_pkg::t_peak                       i_head,
    input  glpd_pkg::t_q_status                   i_q_status,
    output logic                                  o_pop,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic [glpd_pkg::COL_BITS-1:0]         o_peak_x,
    output logic [glpd_pkg::ROW_BITS-1:0]         o_peak_y,
    output logic signed [glpd_pkg::SAMPLE_BITS-1:0] o_peak_value,
    output logic                                  o_is_negative
);

    logic            r_valid;
    glpd_pkg::t_peak r_peak;

    assign o_pop = i_q_status.not_empty && (!r_valid || !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_peak <= i_head;
        end
    end

    assign o_valid       = r_valid;
    assign o_peak_x      = r_peak.x;
    assign o_peak_y      = r_peak.y;
    assign o_peak_value  = r_peak.value;
    assign o_is_negative = r_peak.neg;

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && i_stall) |-> !o_pop)
        else $error("queue popped while output word is held");

endmodule

// ===== src/grid_local_peak_detector.sv =====
// a peak found on the sample that completes its window (one row down and one column
// right of it) passes stage 1, the queue and the output register to reach the output
// throughput: one sample per cycle while o_stall is low; each line store does one read and one write a cycle
// a four-word queue between detection and output absorbs output stalls
// reset: counters to row 0 column 0, defaults loaded, queue and output emptied;
// line stores are not cleared, every entry that a peak check uses is written earlier in the grid
module grid_local_peak_detector (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic signed [glpd_pkg::SAMPLE_BITS-1:0] i_sample,
    input  logic                                  i_cfg_we,
    input  logic [glpd_pkg::CFG_IDX_BITS-1:0]     i_cfg_index,
    input  logic [glpd_pkg::CFG_DATA_BITS-1:0]    i_cfg_data,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic [glpd_pkg::COL_BITS-1:0]         o_peak_x,
    output logic [glpd_pkg::ROW_BITS-1:0]         o_peak_y,
    output logic signed [glpd_pkg::SAMPLE_BITS-1:0] o_peak_value,
    output logic                                  o_is_negative
);

    logic                w_push;
    logic                w_pop;
    glpd_pkg::t_peak     w_peak;
    glpd_pkg::t_peak     w_head;
    glpd_pkg::t_q_status w_q_status;

    glpd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_sample    (i_sample),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_status  (w_q_status),
        .o_push      (w_push),
        .o_peak      (w_peak)
    );

    glpd_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_peak   (w_peak),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_status (w_q_status)
    );

    glpd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (w_head),
        .i_q_status    (w_q_status),
        .o_pop         (w_pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_peak_x      (o_peak_x),
        .o_peak_y      (o_peak_y),
        .o_peak_value  (o_peak_value),
        .o_is_negative (o_is_negative)
    );

endmodule
